FILE: rtl/kee_pkg.sv
// ============================================================================
// kee_pkg
// Shared types, character codes and constants for the keystroke evaluator.
// ============================================================================
`default_nettype none

package kee_pkg;

    // Character codes
    localparam logic [7:0] SYM_ZERO   = 8'h30;
    localparam logic [7:0] SYM_NINE   = 8'h39;
    localparam logic [7:0] SYM_POINT  = 8'h2E;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_TIMES  = 8'h2A;
    localparam logic [7:0] SYM_DIVIDE = 8'h2F;
    localparam logic [7:0] SYM_ROOT   = 8'h72;
    localparam logic [7:0] SYM_SQUARE = 8'h73;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_ROOT_NEG = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

    // Last index of the fraction weight table (weight is zero there)
    localparam logic [3:0] WEIGHT_LAST = 4'd9;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CL_OTHER  = 3'd0,
        CL_DIGIT  = 3'd1,
        CL_POINT  = 3'd2,
        CL_OP     = 3'd3,
        CL_ROOT   = 3'd4,
        CL_SQUARE = 3'd5
    } t_sym_class;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       digit;
        logic       point;
        logic       add;
        logic       sub;
        logic       mul_init;
        logic       sq_init;
        logic       mul_step;
        logic [1:0] mul_idx;
        logic       mul_end;
        logic       div_zero;
        logic       div_init;
        logic       div_step;
        logic       div_end;
        logic       root_neg;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       sqrt_end;
        logic       set_op;
        logic       xf_done;
        logic       out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_sym_class sym_class;
        logic       fin;
        t_op        pend_op;
        logic       acc_neg;
        logic       entry_zero;
        logic       out_full;
    } t_dp_sts;

    // Fraction digit weight in Q0.32: 0.1, then (w + 5) / 10 per digit
    function automatic logic [31:0] frac_weight(input logic [3:0] idx);
        logic [31:0] w;
        case (idx)
            4'd0:    w = 32'd429496730;
            4'd1:    w = 32'd42949673;
            4'd2:    w = 32'd4294967;
            4'd3:    w = 32'd429497;
            4'd4:    w = 32'd42950;
            4'd5:    w = 32'd4295;
            4'd6:    w = 32'd430;
            4'd7:    w = 32'd43;
            4'd8:    w = 32'd4;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/kee_ctrl.sv
// ============================================================================
// kee_ctrl
// Sequencer: decodes each character and steps the datapath through add,
// multiply, divide, root and square sequences, then hands off the result.
// ============================================================================
`default_nettype none

module kee_ctrl #(
    parameter int FRACTION_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  wire kee_pkg::t_dp_sts i_sts,
    output kee_pkg::t_dp_cmd      o_cmd
);

    localparam int DIV_STEPS  = 64 + FRACTION_BITS;
    localparam int SQRT_STEPS = (65 + FRACTION_BITS) / 2;
    localparam int CW         = $clog2(DIV_STEPS);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_APPLY  = 12'b0000_0000_0100,
        S_MUL    = 12'b0000_0000_1000,
        S_MULEND = 12'b0000_0001_0000,
        S_DIV    = 12'b0000_0010_0000,
        S_DIVEND = 12'b0000_0100_0000,
        S_SQRT   = 12'b0000_1000_0000,
        S_SQEND  = 12'b0001_0000_0000,
        S_POST   = 12'b0010_0000_0000,
        S_CHKFIN = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

    // What follows a finished pending-operator step
    typedef enum logic [1:0] {
        PH_OP  = 2'd0,
        PH_XF  = 2'd1,
        PH_XFD = 2'd2,
        PH_FIN = 2'd3
    } t_phase;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_idx = r_cnt[1:0];
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.sym_class)
                    kee_pkg::CL_DIGIT: begin
                        o_cmd.digit = 1'b1;
                        n_state     = S_CHKFIN;
                    end
                    kee_pkg::CL_POINT: begin
                        o_cmd.point = 1'b1;
                        n_state     = S_CHKFIN;
                    end
                    kee_pkg::CL_OP: begin
                        n_phase = PH_OP;
                        n_state = S_APPLY;
                    end
                    kee_pkg::CL_ROOT, kee_pkg::CL_SQUARE: begin
                        n_phase = PH_XF;
                        n_state = S_APPLY;
                    end
                    default: n_state = S_CHKFIN;
                endcase
            end
            S_APPLY: begin
                n_cnt = '0;
                case (i_sts.pend_op)
                    kee_pkg::OP_ADD: begin
                        o_cmd.add = 1'b1;
                        n_state   = S_POST;
                    end
                    kee_pkg::OP_SUB: begin
                        o_cmd.sub = 1'b1;
                        n_state   = S_POST;
                    end
                    kee_pkg::OP_MUL: begin
                        o_cmd.mul_init = 1'b1;
                        n_state        = S_MUL;
                    end
                    default: begin
                        if (i_sts.entry_zero) begin
                            o_cmd.div_zero = 1'b1;
                            n_state        = S_POST;
                        end else begin
                            o_cmd.div_init = 1'b1;
                            n_state        = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == CW'(3)) begin
                    n_state = S_MULEND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MULEND: begin
                o_cmd.mul_end = 1'b1;
                n_state       = S_POST;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    n_state = S_DIVEND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIVEND: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_POST;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CW'(SQRT_STEPS - 1)) begin
                    n_state = S_SQEND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQEND: begin
                o_cmd.sqrt_end = 1'b1;
                n_state        = S_POST;
            end
            S_POST: begin
                n_cnt = '0;
                case (r_phase)
                    PH_OP: begin
                        o_cmd.set_op = 1'b1;
                        n_state      = S_CHKFIN;
                    end
                    PH_XF: begin
                        n_phase = PH_XFD;
                        if (i_sts.sym_class == kee_pkg::CL_ROOT) begin
                            if (i_sts.acc_neg) begin
                                o_cmd.root_neg = 1'b1;
                                n_state        = S_POST;
                            end else begin
                                o_cmd.sqrt_init = 1'b1;
                                n_state         = S_SQRT;
                            end
                        end else begin
                            o_cmd.sq_init = 1'b1;
                            n_state       = S_MUL;
                        end
                    end
                    PH_XFD: begin
                        o_cmd.xf_done = 1'b1;
                        n_state       = S_CHKFIN;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_CHKFIN: begin
                if (i_sts.fin) begin
                    n_phase = PH_FIN;
                    n_state = S_APPLY;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_OP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kee_dp.sv
// ============================================================================
// kee_dp
// Datapath: entry builder, accumulator, shared multiply, restoring divide,
// digit-by-digit square root and the result output register.
// ============================================================================
`default_nettype none

module kee_dp #(
    parameter int FRACTION_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_sym,
    input  wire                   i_fin,
    input  wire kee_pkg::t_dp_cmd i_cmd,
    output kee_pkg::t_dp_sts      o_sts,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [63:0]           o_m_tdata,
    output logic [1:0]            o_m_tuser
);

    localparam int DW   = 64 + FRACTION_BITS;
    localparam int NP   = (65 + FRACTION_BITS) / 2;
    localparam int RW   = 2 * NP;
    localparam int UP   = (FRACTION_BITS >= 32) ? FRACTION_BITS - 32 : 0;
    localparam int DN   = (FRACTION_BITS < 32) ? 32 - FRACTION_BITS : 0;
    localparam int HALF = (FRACTION_BITS < 32) ? 31 - FRACTION_BITS : 0;

    // Control state
    logic [63:0]   r_acc, n_acc;
    logic [63:0]   r_entry, n_entry;
    kee_pkg::t_op  r_pend, n_pend;
    logic          r_infrac, n_infrac;
    logic [3:0]    r_wcnt, n_wcnt;
    logic [1:0]    r_err, n_err;
    logic          r_out_valid, n_out_valid;

    // Payload and working registers
    logic [7:0]    r_sym, n_sym;
    logic          r_fin, n_fin;
    logic [63:0]   r_a, n_a;
    logic [63:0]   r_b, n_b;
    logic          r_neg, n_neg;
    logic [127:0]  r_prod, n_prod;
    logic [DW-1:0] r_dvd, n_dvd;
    logic [RW-1:0] r_rad, n_rad;
    logic [63:0]   r_rem, n_rem;
    logic [63:0]   r_q, n_q;
    logic          r_ovf, n_ovf;
    logic [63:0]   r_out_value, n_out_value;
    logic [1:0]    r_out_status, n_out_status;

    kee_pkg::t_sym_class sym_class;
    logic [1:0]    raise;
    logic [63:0]   mag_acc;
    logic [3:0]    dig;
    logic [67:0]   int_tot;
    logic [35:0]   frac_p;
    logic [63:0]   frac_c;
    logic [64:0]   frac_sum;
    logic [63:0]   sum, diff;
    logic          sum_ovf, diff_ovf;
    logic [31:0]   pp_a, pp_b;
    logic [63:0]   pp;
    logic [1:0]    pp_sh;
    logic [64:0]   mul_res, div_res;
    logic [63:0]   div_rb, sq_rr, sq_trial;
    logic          div_ge, sq_ge;

    // Saturating conversion of a magnitude and sign; bit 64 flags saturation
    function automatic logic [64:0] from_mag(input logic [63:0] mag, input logic neg,
                                             input logic ovf);
        logic [64:0] res;
        if (neg) begin
            if (ovf || mag > kee_pkg::VAL_MIN) res = {1'b1, kee_pkg::VAL_MIN};
            else                               res = {1'b0, 64'd0 - mag};
        end else begin
            if (ovf || mag > kee_pkg::VAL_MAX) res = {1'b1, kee_pkg::VAL_MAX};
            else                               res = {1'b0, mag};
        end
        return res;
    endfunction

    // Character classification
    always_comb begin
        if (r_sym >= kee_pkg::SYM_ZERO && r_sym <= kee_pkg::SYM_NINE)
            sym_class = kee_pkg::CL_DIGIT;
        else if (r_sym == kee_pkg::SYM_POINT)
            sym_class = kee_pkg::CL_POINT;
        else if (r_sym == kee_pkg::SYM_PLUS || r_sym == kee_pkg::SYM_MINUS ||
                 r_sym == kee_pkg::SYM_TIMES || r_sym == kee_pkg::SYM_DIVIDE)
            sym_class = kee_pkg::CL_OP;
        else if (r_sym == kee_pkg::SYM_ROOT)
            sym_class = kee_pkg::CL_ROOT;
        else if (r_sym == kee_pkg::SYM_SQUARE)
            sym_class = kee_pkg::CL_SQUARE;
        else
            sym_class = kee_pkg::CL_OTHER;
    end

    assign o_sts.sym_class  = sym_class;
    assign o_sts.fin        = r_fin;
    assign o_sts.pend_op    = r_pend;
    assign o_sts.acc_neg    = r_acc[63];
    assign o_sts.entry_zero = (r_entry == 64'd0);
    assign o_sts.out_full   = r_out_valid;

    assign mag_acc = r_acc[63] ? 64'd0 - r_acc : r_acc;
    assign dig     = r_sym[3:0];

    // Integer digit: entry * 10 + digit, checked against the largest value
    assign int_tot = ({4'd0, r_entry} << 3) + ({4'd0, r_entry} << 1)
                   + {4'd0, 64'(dig) << FRACTION_BITS};

    // Fraction digit: digit * weight, scaled to the fraction width
    assign frac_p = 36'(dig) * {4'd0, kee_pkg::frac_weight(r_wcnt)};
    assign frac_c = (FRACTION_BITS >= 32) ? ({28'd0, frac_p} << UP)
                  : (({28'd0, frac_p} + (64'd1 << HALF)) >> DN);
    assign frac_sum = {1'b0, r_entry} + {1'b0, frac_c};

    // Add and subtract with overflow detection
    assign sum      = r_acc + r_entry;
    assign diff     = r_acc - r_entry;
    assign sum_ovf  = (r_acc[63] == r_entry[63]) && (sum[63] != r_acc[63]);
    assign diff_ovf = (r_acc[63] != r_entry[63]) && (diff[63] != r_acc[63]);

    // One 32x32 partial product per multiply step
    assign pp_a  = i_cmd.mul_idx[1] ? r_a[63:32] : r_a[31:0];
    assign pp_b  = i_cmd.mul_idx[0] ? r_b[63:32] : r_b[31:0];
    assign pp    = {32'd0, pp_a} * {32'd0, pp_b};
    assign pp_sh = {1'b0, i_cmd.mul_idx[1]} + {1'b0, i_cmd.mul_idx[0]};
    assign mul_res = from_mag(r_prod[FRACTION_BITS +: 64], r_neg,
                              |r_prod[127:FRACTION_BITS + 64]);

    // Restoring divide step
    assign div_rb  = {r_rem[62:0], r_dvd[DW-1]};
    assign div_ge  = (div_rb >= r_b);
    assign div_res = from_mag(r_q, r_neg, r_ovf);

    // Square root step, two radicand bits per step
    assign sq_rr    = {r_rem[61:0], r_rad[RW-1:RW-2]};
    assign sq_trial = {r_q[61:0], 2'b01};
    assign sq_ge    = (sq_rr >= sq_trial);

    // Next-state logic
    always_comb begin
        n_acc        = r_acc;
        n_entry      = r_entry;
        n_pend       = r_pend;
        n_infrac     = r_infrac;
        n_wcnt       = r_wcnt;
        n_err        = r_err;
        n_out_valid  = r_out_valid;
        n_sym        = r_sym;
        n_fin        = r_fin;
        n_a          = r_a;
        n_b          = r_b;
        n_neg        = r_neg;
        n_prod       = r_prod;
        n_dvd        = r_dvd;
        n_rad        = r_rad;
        n_rem        = r_rem;
        n_q          = r_q;
        n_ovf        = r_ovf;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        raise        = kee_pkg::ST_OK;

        if (i_cmd.load) begin
            n_sym = i_sym;
            n_fin = i_fin;
        end

        // Entry building
        if (i_cmd.digit) begin
            if (r_infrac) begin
                if (frac_sum > {1'b0, kee_pkg::VAL_MAX}) begin
                    raise   = kee_pkg::ST_SAT;
                    n_entry = kee_pkg::VAL_MAX;
                end else begin
                    n_entry = frac_sum[63:0];
                end
                if (r_wcnt != kee_pkg::WEIGHT_LAST) n_wcnt = r_wcnt + 1'b1;
            end else begin
                if (int_tot > {4'd0, kee_pkg::VAL_MAX}) begin
                    raise   = kee_pkg::ST_SAT;
                    n_entry = kee_pkg::VAL_MAX;
                end else begin
                    n_entry = int_tot[63:0];
                end
            end
        end
        if (i_cmd.point) n_infrac = 1'b1;

        // Sum and difference
        if (i_cmd.add) begin
            if (sum_ovf) begin
                raise = kee_pkg::ST_SAT;
                n_acc = r_acc[63] ? kee_pkg::VAL_MIN : kee_pkg::VAL_MAX;
            end else begin
                n_acc = sum;
            end
        end
        if (i_cmd.sub) begin
            if (diff_ovf) begin
                raise = kee_pkg::ST_SAT;
                n_acc = r_acc[63] ? kee_pkg::VAL_MIN : kee_pkg::VAL_MAX;
            end else begin
                n_acc = diff;
            end
        end

        // Multiply and square
        if (i_cmd.mul_init) begin
            n_a    = mag_acc;
            n_b    = r_entry;
            n_neg  = r_acc[63] ^ r_entry[63];
            n_prod = '0;
        end
        if (i_cmd.sq_init) begin
            n_a    = mag_acc;
            n_b    = mag_acc;
            n_neg  = 1'b0;
            n_prod = '0;
        end
        if (i_cmd.mul_step) n_prod = r_prod + ({64'd0, pp} << {pp_sh, 5'd0});
        if (i_cmd.mul_end) begin
            n_acc = mul_res[63:0];
            if (mul_res[64]) raise = kee_pkg::ST_SAT;
        end

        // Divide
        if (i_cmd.div_zero) begin
            n_acc = 64'd0;
            raise = kee_pkg::ST_DIV_ZERO;
        end
        if (i_cmd.div_init) begin
            n_dvd = {mag_acc, {FRACTION_BITS{1'b0}}};
            n_b   = r_entry;
            n_neg = r_acc[63] ^ r_entry[63];
            n_rem = '0;
            n_q   = '0;
            n_ovf = 1'b0;
        end
        if (i_cmd.div_step) begin
            n_dvd = r_dvd << 1;
            n_ovf = r_ovf | r_q[63];
            n_rem = div_ge ? div_rb - r_b : div_rb;
            n_q   = {r_q[62:0], div_ge};
        end
        if (i_cmd.div_end) begin
            n_acc = div_res[63:0];
            if (div_res[64]) raise = kee_pkg::ST_SAT;
        end

        // Square root
        if (i_cmd.root_neg) begin
            n_acc = 64'd0;
            raise = kee_pkg::ST_ROOT_NEG;
        end
        if (i_cmd.sqrt_init) begin
            n_rad = RW'({r_acc, {FRACTION_BITS{1'b0}}});
            n_rem = '0;
            n_q   = '0;
        end
        if (i_cmd.sqrt_step) begin
            n_rad = r_rad << 2;
            n_rem = sq_ge ? sq_rr - sq_trial : sq_rr;
            n_q   = {r_q[62:0], sq_ge};
        end
        if (i_cmd.sqrt_end) n_acc = r_q;

        // Operator and entry restart
        if (i_cmd.set_op || i_cmd.xf_done) begin
            n_entry  = 64'd0;
            n_infrac = 1'b0;
            n_wcnt   = 4'd0;
        end
        if (i_cmd.set_op) begin
            case (r_sym)
                kee_pkg::SYM_PLUS:  n_pend = kee_pkg::OP_ADD;
                kee_pkg::SYM_MINUS: n_pend = kee_pkg::OP_SUB;
                kee_pkg::SYM_TIMES: n_pend = kee_pkg::OP_MUL;
                default:            n_pend = kee_pkg::OP_DIV;
            endcase
        end
        if (i_cmd.xf_done) n_pend = kee_pkg::OP_ADD;

        // First error sticks
        if (r_err == kee_pkg::ST_OK) n_err = raise;

        // Output word and return to the starting state
        if (r_out_valid && i_m_tready) n_out_valid = 1'b0;
        if (i_cmd.out_load) begin
            n_out_valid  = 1'b1;
            n_out_value  = r_acc;
            n_out_status = r_err;
            n_acc        = 64'd0;
            n_pend       = kee_pkg::OP_ADD;
            n_err        = kee_pkg::ST_OK;
            n_entry      = 64'd0;
            n_infrac     = 1'b0;
            n_wcnt       = 4'd0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 64'd0;
            r_entry     <= 64'd0;
            r_pend      <= kee_pkg::OP_ADD;
            r_infrac    <= 1'b0;
            r_wcnt      <= 4'd0;
            r_err       <= kee_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_entry     <= n_entry;
            r_pend      <= n_pend;
            r_infrac    <= n_infrac;
            r_wcnt      <= n_wcnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_fin        <= n_fin;
        r_a          <= n_a;
        r_b          <= n_b;
        r_neg        <= n_neg;
        r_prod       <= n_prod;
        r_dvd        <= n_dvd;
        r_rad        <= n_rad;
        r_rem        <= n_rem;
        r_q          <= n_q;
        r_ovf        <= n_ovf;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_status;

    // Checks
    a_entry_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_entry[63])
        else $error("entry went negative");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != kee_pkg::ST_OK && !i_cmd.out_load) |=> (r_err == $past(r_err)))
        else $error("first error overwritten");

    a_root_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_end |=> !r_acc[63])
        else $error("square root result negative");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("output word overwritten");

endmodule

`default_nettype wire

FILE: rtl/keystroke_expression_evaluator_core.sv
// ============================================================================
// keystroke_expression_evaluator_core
// Left-to-right calculator: characters in, signed fixed-point result out.
// ============================================================================
// One character word is taken at a time; the block is busy until it is done.
// A digit, point or ignored character is decoded and then checked for tlast.
// + - * / and r / s first apply the pending operator: add or subtract
// directly, multiply from 32x32 partial products, divide one quotient bit
// per cycle in the restoring divider. r then runs the root unit (a negative
// value gives zero and a status code instead), s the multiply unit. A word
// with tlast set then applies the pending operator and loads the output
// register, which waits while the previous result is not taken; that register
// lets the next expression start while the result waits.
`default_nettype none

module keystroke_expression_evaluator_core #(
    parameter int FRACTION_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] symbol
    input  wire         i_s_tlast,   // final_req
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] value
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    kee_pkg::t_dp_cmd cmd;
    kee_pkg::t_dp_sts sts;

    kee_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    kee_dp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sym     (i_s_tdata),
        .i_fin     (i_s_tlast),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/tb_keystroke_expression_evaluator_core.sv
// ============================================================================
// tb_keystroke_expression_evaluator_core
// Self-checking bench for the left-to-right keystroke evaluator.
// ============================================================================
// Character words are fed in on the slave stream with random gaps. Every
// accepted word also runs through a fixed-point evaluator model kept here.
// Each result word on the master stream is checked against the oldest
// expected result. A short directed table comes first, then random
// expressions, mostly well formed, with some noise characters mixed in.
`default_nettype none

module tb_keystroke_expression_evaluator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FB      = 32;
    localparam logic [31:0] TENTH   = 32'h1999_999A;
    localparam int          SETTLE  = 300;

    typedef struct {
        logic [7:0]  sym;
        logic        last;
        logic        chk;
        logic [63:0] val;
        logic [1:0]  st;
    } t_key_row;

    typedef struct {
        logic [63:0] val;
        logic [1:0]  st;
    } t_calc_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    keystroke_expression_evaluator_core #(.FRACTION_BITS(FB)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] symbol
        .i_s_tlast  (i_s_tlast),   // final_req
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [63:0] value
        .o_m_tuser  (o_m_tuser)    // [1:0] status
    );

    // Model state
    logic signed [63:0] acc;
    logic [63:0]        entry;
    kee_pkg::t_op       pend;
    logic               in_frac;
    logic [31:0]        weight;
    logic [1:0]         err;

    t_key_row  keys[$];
    t_calc_res expected_results[$];
    int        fail_cnt;
    int        words_sent;
    int        results_seen;
    bit        feed_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Evaluator model
    // ------------------------------------------------------------------
    function automatic void raise(input logic [1:0] code);
        if (err == kee_pkg::ST_OK) err = code;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg,
                                             input logic ovf);
        if (neg) begin
            if (ovf || m > kee_pkg::VAL_MIN) begin
                raise(kee_pkg::ST_SAT);
                return kee_pkg::VAL_MIN;
            end
            return 64'd0 - m;
        end
        if (ovf || m > kee_pkg::VAL_MAX) begin
            raise(kee_pkg::ST_SAT);
            return kee_pkg::VAL_MAX;
        end
        return m;
    endfunction

    function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                               input logic sub);
        logic [63:0] s;
        logic        sb;
        s  = sub ? a - b : a + b;
        sb = sub ? ~b[63] : b[63];
        if (a[63] == sb && s[63] != a[63]) begin
            raise(kee_pkg::ST_SAT);
            return a[63] ? kee_pkg::VAL_MIN : kee_pkg::VAL_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
                                           input logic neg);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return from_mag(p[FB+63:FB], neg, p[127:FB+64] != 0);
    endfunction

    function automatic logic [63:0] fx_div(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
        logic [127:0] q;
        if (b == 0) begin
            raise(kee_pkg::ST_DIV_ZERO);
            return 64'd0;
        end
        q = ({64'd0, mag(a)} << FB) / {64'd0, mag(b)};
        return from_mag(q[63:0], a[63] != b[63], q[127:64] != 0);
    endfunction

    function automatic logic [63:0] fx_root(input logic signed [63:0] a);
        logic [127:0] x, r, t;
        if (a[63]) begin
            raise(kee_pkg::ST_ROOT_NEG);
            return 64'd0;
        end
        x = {64'd0, a} << FB;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= x) r = t;
        end
        return r[63:0];
    endfunction

    function automatic void fold_pending();
        case (pend)
            kee_pkg::OP_ADD: acc = sat_addsub(acc, entry, 1'b0);
            kee_pkg::OP_SUB: acc = sat_addsub(acc, entry, 1'b1);
            kee_pkg::OP_MUL: acc = fx_mul(mag(acc), entry, acc[63]);
            default:         acc = fx_div(acc, entry);
        endcase
    endfunction

    function automatic void clear_entry();
        entry   = 64'd0;
        in_frac = 1'b0;
        weight  = TENTH;
    endfunction

    function automatic void clear_calc();
        acc  = 64'd0;
        pend = kee_pkg::OP_ADD;
        err  = kee_pkg::ST_OK;
        clear_entry();
    endfunction

    function automatic void push_digit(input logic [63:0] d);
        logic [63:0] c;
        if (in_frac) begin
            c = d * {32'd0, weight};
            if (entry > kee_pkg::VAL_MAX - c) begin
                raise(kee_pkg::ST_SAT);
                entry = kee_pkg::VAL_MAX;
            end else begin
                entry = entry + c;
            end
            weight = ({32'd0, weight} + 64'd5) / 64'd10;
        end else begin
            c = d << FB;
            if (entry > (kee_pkg::VAL_MAX - c) / 64'd10) begin
                raise(kee_pkg::ST_SAT);
                entry = kee_pkg::VAL_MAX;
            end else begin
                entry = entry * 64'd10 + c;
            end
        end
    endfunction

    // One keystroke; returns 1 with the result when it closes an expression
    function automatic bit eval_key(input logic [7:0] sym, input logic last,
                                    output t_calc_res res);
        if (sym >= kee_pkg::SYM_ZERO && sym <= kee_pkg::SYM_NINE) begin
            push_digit({56'd0, sym - kee_pkg::SYM_ZERO});
        end else if (sym == kee_pkg::SYM_POINT) begin
            in_frac = 1'b1;
        end else if (sym == kee_pkg::SYM_PLUS || sym == kee_pkg::SYM_MINUS ||
                     sym == kee_pkg::SYM_TIMES || sym == kee_pkg::SYM_DIVIDE) begin
            fold_pending();
            if (sym == kee_pkg::SYM_PLUS)       pend = kee_pkg::OP_ADD;
            else if (sym == kee_pkg::SYM_MINUS) pend = kee_pkg::OP_SUB;
            else if (sym == kee_pkg::SYM_TIMES) pend = kee_pkg::OP_MUL;
            else                                pend = kee_pkg::OP_DIV;
            clear_entry();
        end else if (sym == kee_pkg::SYM_ROOT || sym == kee_pkg::SYM_SQUARE) begin
            fold_pending();
            acc  = sym == kee_pkg::SYM_ROOT ? fx_root(acc)
                                             : fx_mul(mag(acc), mag(acc), 1'b0);
            pend = kee_pkg::OP_ADD;
            clear_entry();
        end
        if (!last) return 0;
        fold_pending();
        res.val = acc;
        res.st  = err;
        clear_calc();
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic key(input logic [7:0] sym, input logic last = 1'b0,
                       input logic chk = 1'b0, input logic [63:0] val = 64'd0,
                       input logic [1:0] st = kee_pkg::ST_OK);
        t_key_row k;
        k.sym = sym; k.last = last; k.chk = chk; k.val = val; k.st = st;
        keys.push_back(k);
    endtask

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return kee_pkg::SYM_PLUS;
            1:       return kee_pkg::SYM_MINUS;
            2:       return kee_pkg::SYM_TIMES;
            default: return kee_pkg::SYM_DIVIDE;
        endcase
    endfunction

    // Number with optional fraction; long runs now and then
    task automatic rand_number();
        int n_int, n_frac;
        n_int  = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4);
        n_frac = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 3);
        for (int i = 0; i < n_int; i++) key(kee_pkg::SYM_ZERO + 8'($urandom_range(0, 9)));
        if (n_frac > 0 || $urandom_range(0, 3) == 0) begin
            key(kee_pkg::SYM_POINT);
            if ($urandom_range(0, 7) == 0) key(kee_pkg::SYM_POINT);
            for (int i = 0; i < n_frac; i++)
                key(kee_pkg::SYM_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic rand_expression();
        int n_terms;
        n_terms = $urandom_range(1, 4);
        for (int t = 0; t < n_terms; t++) begin
            if ($urandom_range(0, 9) == 0) key(8'($urandom_range(0, 255)));
            rand_number();
            case ($urandom_range(0, 9))
                0:       key(kee_pkg::SYM_ROOT);
                1:       key(kee_pkg::SYM_SQUARE);
                default: if (t != n_terms - 1) key(rand_op());
            endcase
        end
        // last word: usually a digit, sometimes an operator or a random character
        case ($urandom_range(0, 3))
            0:       key(8'($urandom_range(0, 255)), 1'b1);
            1:       key(rand_op(), 1'b1);
            default: key(kee_pkg::SYM_ZERO + 8'($urandom_range(0, 9)), 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: slave side
    // ------------------------------------------------------------------
    initial begin
        t_key_row  k;
        t_calc_res res;
        int        gap;
        bit        calm;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'd0;
        i_s_tlast  = 1'b0;
        fail_cnt   = 0;
        words_sent = 0;
        feed_done  = 0;
        clear_calc();

        // Directed table: sym, last, checked, value, status
        key(kee_pkg::SYM_ZERO + 8'd5, 1'b1, 1'b1, 64'd5 << FB, kee_pkg::ST_OK);
        key(kee_pkg::SYM_ZERO + 8'd1);
        key(kee_pkg::SYM_DIVIDE);
        key(kee_pkg::SYM_ZERO, 1'b1, 1'b1, 64'd0, kee_pkg::ST_DIV_ZERO);
        key(kee_pkg::SYM_MINUS);
        key(kee_pkg::SYM_ZERO + 8'd1);
        key(kee_pkg::SYM_ROOT);
        key(8'h20, 1'b1, 1'b1, 64'd0, kee_pkg::ST_ROOT_NEG);
        repeat (5) key(kee_pkg::SYM_NINE);
        key(kee_pkg::SYM_SQUARE, 1'b1, 1'b1, kee_pkg::VAL_MAX, kee_pkg::ST_SAT);
        key(kee_pkg::SYM_ZERO + 8'd1);
        key(kee_pkg::SYM_POINT);
        key(kee_pkg::SYM_ZERO + 8'd5);
        key(kee_pkg::SYM_TIMES);
        key(kee_pkg::SYM_POINT);
        key(kee_pkg::SYM_POINT);
        key(kee_pkg::SYM_ZERO + 8'd2, 1'b1);
        key(kee_pkg::SYM_ZERO + 8'd7);
        key(kee_pkg::SYM_MINUS);
        key(kee_pkg::SYM_ZERO + 8'd2);
        key(kee_pkg::SYM_DIVIDE);
        key(kee_pkg::SYM_ZERO + 8'd3);
        key(8'hFF, 1'b1);
        key(kee_pkg::SYM_ZERO + 8'd2);
        key(kee_pkg::SYM_ROOT, 1'b1);
        key(8'h00, 1'b1, 1'b1, 64'd0, kee_pkg::ST_OK);

        while (keys.size() < 720) rand_expression();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        calm = 0;
        foreach (keys[i]) begin
            k = keys[i];
            if (i % 64 == 0) calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                i_s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_s_tvalid = 1'b1;
            i_s_tdata  = k.sym;
            i_s_tlast  = k.last;
            do @(posedge i_clk); while (!o_s_tready);
            words_sent++;
            if (eval_key(k.sym, k.last, res)) begin
                if (k.chk) begin
                    res.val = k.val;
                    res.st  = k.st;
                end
                expected_results.push_back(res);
            end
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b0;
        feed_done  = 1;
    end

    // ------------------------------------------------------------------
    // Receiver: master side, checks each result word
    // ------------------------------------------------------------------
    initial begin
        t_calc_res exp_r;
        int        stall;
        i_m_tready   = 1'b0;
        results_seen = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            i_m_tready = (stall == 0);
            if (stall > 0) begin
                repeat (stall) @(negedge i_clk);
                i_m_tready = 1'b1;
            end
            do @(posedge i_clk); while (!o_m_tvalid);
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result word: value %h status %0d", o_m_tdata, o_m_tuser);
                fail_cnt++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_m_tdata !== exp_r.val) begin
                    $error("value: expected %h, got %h", exp_r.val, o_m_tdata);
                    fail_cnt++;
                end
                if (o_m_tuser !== exp_r.st) begin
                    $error("status: expected %0d, got %0d", exp_r.st, o_m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------
    initial begin
        wait (feed_done);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d character words, checked %0d results (directed and random).",
                 words_sent, results_seen);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
